[hw/rtl/dequ_pkg.sv]
// ----------------------------------------------------------------------------
// dequ_pkg
// Shared types and codes for the double-ended queue unit.
// ----------------------------------------------------------------------------
package dequ_pkg;

    localparam int unsigned OCC_W = 5;
    localparam int unsigned WORD_W = 32;

    typedef logic [OCC_W-1:0] t_occ;
    typedef logic signed [WORD_W-1:0] t_word;

    typedef enum logic [1:0] {
        CMD_PUSH_HEAD = 2'd0,
        CMD_PUSH_TAIL = 2'd1,
        CMD_POP_HEAD  = 2'd2,
        CMD_POP_TAIL  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic    pop_ok;
        logic    pop_empty;
        t_status status;
        logic    now_empty;
        t_occ    occupancy;
    } t_meta;

endpackage

[hw/rtl/dequ_store.sv]
// ----------------------------------------------------------------------------
// dequ_store
// Ring entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dequ_store import dequ_pkg::*; #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_word         i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output t_word         o_rdata
);

    t_word r_mem [DEPTH];
    t_word r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rd_data <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rd_data;

endmodule

[hw/rtl/dequ_ctrl.sv]
// ----------------------------------------------------------------------------
// dequ_ctrl
// Head/tail pointers and entry count; issues store accesses per command.
// ----------------------------------------------------------------------------
module dequ_ctrl import dequ_pkg::*; #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = 4,
    parameter int unsigned CW    = 5
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_fire,
    input  logic [1:0]    i_command,
    output logic          o_we,
    output logic [AW-1:0] o_waddr,
    output logic          o_re,
    output logic [AW-1:0] o_raddr,
    output t_meta         o_meta
);

    logic [AW-1:0] r_front, n_front;
    logic [AW-1:0] r_back,  n_back;
    logic [CW-1:0] r_count, n_count;

    logic [AW-1:0] front_prev, front_next, back_prev, back_next;
    logic          is_full, is_empty;
    t_cmd          cmd;

    assign cmd      = t_cmd'(i_command);
    assign is_full  = (r_count == CW'(DEPTH));
    assign is_empty = (r_count == '0);

    assign front_prev = (r_front == '0) ? AW'(DEPTH - 1) : r_front - AW'(1);
    assign front_next = (r_front == AW'(DEPTH - 1)) ? '0 : r_front + AW'(1);
    assign back_prev  = (r_back == '0) ? AW'(DEPTH - 1) : r_back - AW'(1);
    assign back_next  = (r_back == AW'(DEPTH - 1)) ? '0 : r_back + AW'(1);

    always_comb begin
        n_front          = r_front;
        n_back           = r_back;
        n_count          = r_count;
        o_we             = 1'b0;
        o_waddr          = r_back;
        o_re             = 1'b0;
        o_raddr          = r_front;
        o_meta.pop_ok    = 1'b0;
        o_meta.pop_empty = 1'b0;
        o_meta.status    = ST_DONE;
        case (cmd)
            CMD_PUSH_HEAD: begin
                if (is_full) begin
                    o_meta.status = ST_FULL;
                end else begin
                    o_we    = i_fire;
                    o_waddr = front_prev;
                    n_front = front_prev;
                    n_count = r_count + CW'(1);
                end
            end
            CMD_PUSH_TAIL: begin
                if (is_full) begin
                    o_meta.status = ST_FULL;
                end else begin
                    o_we    = i_fire;
                    o_waddr = r_back;
                    n_back  = back_next;
                    n_count = r_count + CW'(1);
                end
            end
            CMD_POP_HEAD: begin
                if (is_empty) begin
                    o_meta.status    = ST_EMPTY;
                    o_meta.pop_empty = 1'b1;
                end else begin
                    o_re          = i_fire;
                    o_raddr       = r_front;
                    o_meta.pop_ok = 1'b1;
                    n_front       = front_next;
                    n_count       = r_count - CW'(1);
                end
            end
            CMD_POP_TAIL: begin
                if (is_empty) begin
                    o_meta.status    = ST_EMPTY;
                    o_meta.pop_empty = 1'b1;
                end else begin
                    o_re          = i_fire;
                    o_raddr       = back_prev;
                    o_meta.pop_ok = 1'b1;
                    n_back        = back_prev;
                    n_count       = r_count - CW'(1);
                end
            end
            default: begin
                o_meta.status = ST_DONE;
            end
        endcase
        o_meta.now_empty = (n_count == '0);
        o_meta.occupancy = t_occ'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_back  <= '0;
            r_count <= '0;
        end else if (i_fire) begin
            r_front <= n_front;
            r_back  <= n_back;
            r_count <= n_count;
        end
    end

endmodule

[hw/rtl/double_ended_queue_unit.sv]
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// Bounded double-ended queue of signed 32-bit words in a DEPTH-entry ring.
// ----------------------------------------------------------------------------
// One command is accepted per clock cycle unless the receiver stalls the
// result stages. Each transaction passes through two stages: the pointer
// update with the store's registered read, then the output register. Pushes
// write at acceptance and pops read at acceptance, so a pop always sees
// every earlier push. A push into a full queue is dropped with status 2; a
// pop on an empty queue returns -1 with status 1. Occupancy is reported
// modulo 32.
module double_ended_queue_unit import dequ_pkg::*; #(
    parameter int unsigned DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_command,
    input  t_word       i_push_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_word       o_popped_value,
    output logic [1:0]  o_status,
    output logic        o_now_empty,
    output logic [4:0]  o_occupancy
);

    localparam int unsigned AW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic          fire, s1_move;
    logic          we, re;
    logic [AW-1:0] waddr, raddr;
    t_word         rdata;
    t_meta         meta;

    logic          r_s1_valid;
    t_meta         r_s1_meta;
    logic          r_out_valid;
    t_word         r_out_value;
    t_meta         r_out_meta;

    assign s1_move    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_move;
    assign fire       = i_in_valid && o_in_ready;

    dequ_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_command (i_command),
        .o_we      (we),
        .o_waddr   (waddr),
        .o_re      (re),
        .o_raddr   (raddr),
        .o_meta    (meta)
    );

    dequ_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_push_value),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_s1_meta <= meta;
        end
        if (s1_move) begin
            r_out_meta <= r_s1_meta;
            if (r_s1_meta.pop_ok) begin
                r_out_value <= rdata;
            end else if (r_s1_meta.pop_empty) begin
                r_out_value <= '1;
            end else begin
                r_out_value <= '0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_popped_value = r_out_value;
    assign o_status       = r_out_meta.status;
    assign o_now_empty    = r_out_meta.now_empty;
    assign o_occupancy    = r_out_meta.occupancy;

    a_empty_pop_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_EMPTY) |-> (o_popped_value == '1 && o_now_empty))
        else $error("empty pop result malformed");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_move) |=> (r_s1_valid && $stable(r_s1_meta)))
        else $error("stalled stage lost its transaction");

    a_empty_matches_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && DEPTH < 32) |-> (o_now_empty == (o_occupancy == '0)))
        else $error("empty flag disagrees with occupancy");

    a_push_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_FULL) |-> (o_popped_value == '0))
        else $error("dropped push returned nonzero word");

endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for double_ended_queue_unit. A tracker class mirrors
// the ring store, both pointers and the entry count, predicts the result of
// every accepted command and checks the results in order. Stimulus opens with
// empty pops, extreme words, a fill to full and pushes into a full queue. It
// then runs random bursts that lean toward filling, toward draining or
// neither. The sender idles in random gaps and the receiver stalls on its own
// pattern, with long hold-offs and a full drain in between.
// ----------------------------------------------------------------------------
module testbench import dequ_pkg::*;;

    localparam int unsigned QUEUE_DEPTH  = 16;
    localparam int unsigned RANDOM_ITEMS = 1680;
    localparam int unsigned HOLD_CYCLES  = 150;
    localparam int unsigned IDLE_LIMIT   = 4000;
    localparam int unsigned PRINT_CAP    = 40;

    typedef struct {
        t_word   popped_value;
        t_status status;
        logic    now_empty;
        t_occ    occupancy;
    } t_deque_outcome;

    class deque_tracker;
        t_word          slots [QUEUE_DEPTH];
        int unsigned    front_ptr;
        int unsigned    back_ptr;
        int unsigned    held;
        t_deque_outcome awaited [$];
        int unsigned    errors;
        int unsigned    pushes;
        int unsigned    pops;
        int unsigned    full_drops;
        int unsigned    empty_pops;
        int unsigned    peak;
        int unsigned    checked;

        function new();
            front_ptr  = 0;
            back_ptr   = 0;
            held       = 0;
            errors     = 0;
            pushes     = 0;
            pops       = 0;
            full_drops = 0;
            empty_pops = 0;
            peak       = 0;
            checked    = 0;
        endfunction

        function int unsigned pending();
            return awaited.size();
        endfunction

        task report(string msg);
            errors++;
            if (errors <= PRINT_CAP) begin
                $display("MISMATCH %0d: %s", errors, msg);
            end
        endtask

        function void note_command(t_cmd cmd, t_word word);
            t_deque_outcome r;
            r.popped_value = '0;
            r.status       = ST_DONE;
            case (cmd)
                CMD_PUSH_HEAD, CMD_PUSH_TAIL: begin
                    if (held == QUEUE_DEPTH) begin
                        r.status = ST_FULL;
                        full_drops++;
                    end else begin
                        if (cmd == CMD_PUSH_HEAD) begin
                            front_ptr = (front_ptr == 0) ? QUEUE_DEPTH - 1 : front_ptr - 1;
                            slots[front_ptr] = word;
                        end else begin
                            slots[back_ptr] = word;
                            back_ptr = (back_ptr + 1) % QUEUE_DEPTH;
                        end
                        held++;
                        pushes++;
                    end
                end
                default: begin
                    if (held == 0) begin
                        r.popped_value = -1;
                        r.status       = ST_EMPTY;
                        empty_pops++;
                    end else begin
                        if (cmd == CMD_POP_HEAD) begin
                            r.popped_value = slots[front_ptr];
                            front_ptr = (front_ptr + 1) % QUEUE_DEPTH;
                        end else begin
                            back_ptr = (back_ptr == 0) ? QUEUE_DEPTH - 1 : back_ptr - 1;
                            r.popped_value = slots[back_ptr];
                        end
                        held--;
                        pops++;
                    end
                end
            endcase
            if (held > peak) begin
                peak = held;
            end
            r.now_empty = (held == 0);
            r.occupancy = t_occ'(held);
            awaited.push_back(r);
        endfunction

        task check_result(t_word value, logic [1:0] status, logic empty, t_occ occ);
            t_deque_outcome r;
            if (awaited.size() == 0) begin
                report("result transaction with no command outstanding");
                return;
            end
            r = awaited.pop_front();
            checked++;
            if (value !== r.popped_value) begin
                report($sformatf("result %0d popped_value got %0d expected %0d",
                                 checked, value, r.popped_value));
            end
            if (status !== r.status) begin
                report($sformatf("result %0d status got %0d expected %0d",
                                 checked, status, r.status));
            end
            if (empty !== r.now_empty) begin
                report($sformatf("result %0d now_empty got %0b expected %0b",
                                 checked, empty, r.now_empty));
            end
            if (occ !== r.occupancy) begin
                report($sformatf("result %0d occupancy got %0d expected %0d",
                                 checked, occ, r.occupancy));
            end
        endtask
    endclass

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic        in_ready;
    t_cmd        command      = CMD_PUSH_HEAD;
    t_word       push_value   = '0;
    logic        out_valid;
    logic        out_ready    = 1'b0;
    t_word       popped_value;
    logic [1:0]  status;
    logic        now_empty;
    logic [4:0]  occupancy;

    logic        stall_req    = 1'b0;
    int unsigned idle_cycles  = 0;

    deque_tracker tracker = new();

    double_ended_queue_unit #(
        .DEPTH(QUEUE_DEPTH)
    ) dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_command      (command),
        .i_push_value   (push_value),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_popped_value (popped_value),
        .o_status       (status),
        .o_now_empty    (now_empty),
        .o_occupancy    (occupancy)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready) begin
                tracker.note_command(command, push_value);
            end
            if (out_valid && out_ready) begin
                tracker.check_result(popped_value, status, now_empty, occupancy);
            end
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("Watchdog: no transaction for %0d cycles", idle_cycles);
                    $display("CHECKS FAILED");
                    $finish;
                end
            end
        end
    end

    initial begin
        int unsigned run_left;
        int unsigned hold_left;
        int unsigned ready_mode;
        run_left   = 0;
        hold_left  = 0;
        ready_mode = 0;
        forever begin
            @(negedge clk);
            if (stall_req) begin
                hold_left = HOLD_CYCLES;
                stall_req = 1'b0;
            end
            if (hold_left != 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end else begin
                if (run_left == 0) begin
                    run_left   = $urandom_range(4, 48);
                    ready_mode = $urandom_range(0, 3);
                end
                run_left--;
                case (ready_mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= ($urandom_range(0, 1) == 1);
                    2: out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= 1'b0;
                endcase
            end
        end
    end

    task send_command(t_cmd cmd, t_word word);
        in_valid   <= 1'b1;
        command    <= cmd;
        push_value <= word;
        @(posedge clk);
        while (!in_ready) begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task pause_sender(int unsigned cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    task drain_results();
        in_valid <= 1'b0;
        while (tracker.pending() != 0) begin
            @(negedge clk);
        end
    endtask

    function t_word pick_word();
        case ($urandom_range(0, 9))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return -1;
            3: return '0;
            default: return $urandom;
        endcase
    endfunction

    task send_random(int unsigned push_pct);
        t_cmd cmd;
        if ($urandom_range(0, 99) < push_pct) begin
            cmd = $urandom_range(0, 1) ? CMD_PUSH_TAIL : CMD_PUSH_HEAD;
        end else begin
            cmd = $urandom_range(0, 1) ? CMD_POP_TAIL : CMD_POP_HEAD;
        end
        send_command(cmd, pick_word());
    endtask

    initial begin
        int unsigned sent;
        int unsigned burst;
        int unsigned push_pct;
        int unsigned holds_done;
        bit          drained;
        sent       = 0;
        holds_done = 0;
        drained    = 1'b0;

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_command(CMD_POP_HEAD, pick_word());
        send_command(CMD_POP_TAIL, pick_word());
        send_command(CMD_PUSH_HEAD, 32'sh7fff_ffff);
        send_command(CMD_PUSH_TAIL, 32'sh8000_0000);
        send_command(CMD_PUSH_HEAD, -1);
        send_command(CMD_POP_TAIL, '0);
        send_command(CMD_POP_HEAD, '0);
        send_command(CMD_POP_HEAD, '0);
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            send_command(i[0] ? CMD_PUSH_TAIL : CMD_PUSH_HEAD, t_word'(i * 32'h1111_1111));
        end
        send_command(CMD_PUSH_HEAD, 32'sh5a5a_5a5a);
        send_command(CMD_PUSH_TAIL, 32'sha5a5_a5a5);
        drain_results();

        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 32);
            case ($urandom_range(0, 2))
                0: push_pct = 80;
                1: push_pct = 50;
                default: push_pct = 20;
            endcase
            repeat (burst) begin
                send_random(push_pct);
                sent++;
            end
            if (holds_done < 2 && sent >= 400 + 800 * holds_done) begin
                stall_req  = 1'b1;
                holds_done++;
            end
            if (!drained && sent >= 900) begin
                drain_results();
                drained = 1'b1;
            end else if ($urandom_range(0, 3) != 0) begin
                pause_sender($urandom_range(1, 12));
            end
        end
        drain_results();
        repeat (8) @(posedge clk);

        if (tracker.pending() != 0) begin
            tracker.report($sformatf("%0d expected results never arrived", tracker.pending()));
        end
        $display("Run covered %0d commands: %0d pushes, %0d dropped on full, %0d pops, %0d %s",
                 tracker.pushes + tracker.full_drops + tracker.pops + tracker.empty_pops,
                 tracker.pushes, tracker.full_drops, tracker.pops, tracker.empty_pops,
                 "on empty.");
        $display("Peak occupancy %0d of %0d; %0d results checked, %0d mismatches.",
                 tracker.peak, QUEUE_DEPTH, tracker.checked, tracker.errors);
        if (tracker.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
